>>> design/sorted_table_binary_search_top_macros.svh
// Assertion macros shared by the checker of the sorted-table search block.
// Depends on nothing; included by the checker file.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define STBS_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define STBS_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/stbs_pkg.sv
// Types and constants of the sorted-table search block.
// Depends on nothing; used by every module of the block.
package stbs_pkg;

	localparam int IDX_W       = 6;
	localparam int VAL_W       = 32;
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 8;

	// Item kinds carried in the input tuser
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                    op;
		logic [IDX_W-1:0]        entry_index;
		logic signed [VAL_W-1:0] entry_value;
		logic signed [VAL_W-1:0] search_key;
		logic [IDX_W-1:0]        range_low;
		logic [IDX_W-1:0]        range_high;
	} item_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] position;
	} result_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

>>> design/sorted_table_binary_search_top.sv
// Sorted-table binary search, top level: stream ports, output register,
// sequencer and table memory. Depends on stbs_pkg, stbs_engine, stbs_table.
//
// Usage. Each input beat is one item; s_axis_tuser says whether it writes a
// table entry or searches. A write stores entry_value at entry_index (ignored
// when the index is DEPTH or beyond) and gives no output beat. Software loads
// the table in ascending order before searching it. A search gives exactly one
// output beat: m_axis_tuser is the found flag, m_axis_tdata the position
// (zero when not found). The high bound of the range is clamped to DEPTH-1.
// Sequencing: a search goes from the probe state through one compare per
// probe, P probes in all (at most clog2(DEPTH)+1), to the done state; each
// probe is one read of the single table port plus a compare, and the next
// item is taken once the result reaches the output register. The output
// register holds a finished result while the receiver stalls and the block
// keeps taking writes; a second search is taken, but its result waits in the
// sequencer for the register to drain. Reset clears control state only;
// table entries are undefined until written and need no clearing pass.
module sorted_table_binary_search_top #(
	parameter int DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// entry_index, entry_value, search_key, range_low, range_high, zero fill
	input  logic [stbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// op
	input  logic [0:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// position, zero fill
	output logic [stbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// found
	output logic [0:0]                          m_axis_tuser
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW = stbs_pkg::IDX_W;
	localparam int VW = stbs_pkg::VAL_W;

	stbs_pkg::item_t    item;
	stbs_pkg::mem_ctl_t mem_ctl;
	stbs_pkg::result_t  res;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic [VW-1:0]      wr_data, rd_data;
	logic               res_valid, res_ready;
	logic               out_valid_q, out_found_q;
	logic [IW-1:0]      out_pos_q;

	// Unpack the input beat
	always_comb begin
		item.op          = s_axis_tuser[0];
		item.entry_index = s_axis_tdata[IW-1:0];
		item.entry_value = s_axis_tdata[IW+VW-1:IW];
		item.search_key  = s_axis_tdata[IW+2*VW-1:IW+VW];
		item.range_low   = s_axis_tdata[2*IW+2*VW-1:IW+2*VW];
		item.range_high  = s_axis_tdata[3*IW+2*VW-1:2*IW+2*VW];
	end

	stbs_engine #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.item     (item),
		.mem_ctl  (mem_ctl),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	stbs_table #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.ctl    (mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Load the output register when it is empty or being drained
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_found_q <= res.found;
			out_pos_q   <= res.position;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(stbs_pkg::OUT_TDATA_W - IW){1'b0}}, out_pos_q};
	assign m_axis_tuser  = out_found_q;

endmodule

>>> design/stbs_table.sv
// Table storage: one synchronous memory, one write and one registered read port.
// Depends on stbs_pkg for the value width and the port control struct.
module stbs_table #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                        clk,
	input  stbs_pkg::mem_ctl_t          ctl,
	input  logic [AW-1:0]               wr_addr,
	input  logic [stbs_pkg::VAL_W-1:0]  wr_data,
	input  logic [AW-1:0]               rd_addr,
	output logic [stbs_pkg::VAL_W-1:0]  rd_data
);

	logic [stbs_pkg::VAL_W-1:0] mem_q [DEPTH];
	logic [stbs_pkg::VAL_W-1:0] rd_data_q;

	// Store an entry
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read one entry, data valid the next cycle
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/stbs_engine.sv
// Search sequencer: takes items, drives the table ports and narrows the range.
// Depends on stbs_pkg; drives an stbs_table instance placed by the top level.
module stbs_engine #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  stbs_pkg::item_t             item,
	output stbs_pkg::mem_ctl_t          mem_ctl,
	output logic [AW-1:0]               wr_addr,
	output logic [stbs_pkg::VAL_W-1:0]  wr_data,
	output logic [AW-1:0]               rd_addr,
	input  logic [stbs_pkg::VAL_W-1:0]  rd_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output stbs_pkg::result_t           res
);

	localparam int IW = stbs_pkg::IDX_W;

	stbs_pkg::state_t               state_q, state_n;
	logic signed [stbs_pkg::VAL_W-1:0] key_q;
	logic [IW-1:0]                  lo_q, hi_q, mid_q;
	logic [IW-1:0]                  lo_n, hi_n, mid_c, mid_n, hi_clamp;
	logic [IW:0]                    sum_c, sum_n;
	logic                           found_q, found_n;
	logic [IW-1:0]                  pos_q, pos_n;
	logic                           accept, is_eq, is_gt, range_empty, last_probe;

	assign accept = in_valid && in_ready;

	// Clamp the high bound to the last table entry
	always_comb begin
		if (32'(item.range_high) > 32'(DEPTH - 1)) begin
			hi_clamp = IW'(DEPTH - 1);
		end else begin
			hi_clamp = item.range_high;
		end
	end

	// Probe arithmetic: midpoint of the held range and of the narrowed range
	always_comb begin
		sum_c       = {1'b0, lo_q} + {1'b0, hi_q};
		mid_c       = sum_c[IW:1];
		range_empty = lo_q > hi_q;
		is_eq       = key_q == $signed(rd_data);
		is_gt       = key_q > $signed(rd_data);
		lo_n        = lo_q;
		hi_n        = hi_q;
		if (is_gt) begin
			lo_n       = mid_q + IW'(1);
			last_probe = mid_q == hi_q;
		end else begin
			hi_n       = mid_q - IW'(1);
			last_probe = mid_q == lo_q;
		end
		sum_n = {1'b0, lo_n} + {1'b0, hi_n};
		mid_n = sum_n[IW:1];
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			stbs_pkg::ST_IDLE: begin
				if (accept && item.op == stbs_pkg::OP_SEARCH) begin
					state_n = stbs_pkg::ST_PROBE;
				end
			end
			stbs_pkg::ST_PROBE: begin
				state_n = range_empty ? stbs_pkg::ST_DONE : stbs_pkg::ST_CMP;
			end
			stbs_pkg::ST_CMP: begin
				if (is_eq || last_probe) begin
					state_n = stbs_pkg::ST_DONE;
				end
			end
			stbs_pkg::ST_DONE: begin
				if (res_ready) begin
					state_n = stbs_pkg::ST_IDLE;
				end
			end
			default: state_n = stbs_pkg::ST_IDLE;
		endcase
	end

	// Outputs: handshake, table ports and the result to be held
	always_comb begin
		in_ready      = 1'b0;
		res_valid     = 1'b0;
		mem_ctl.wr_en = 1'b0;
		mem_ctl.rd_en = 1'b0;
		rd_addr       = AW'(mid_c);
		found_n       = found_q;
		pos_n         = pos_q;
		unique case (state_q)
			stbs_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				mem_ctl.wr_en = accept && item.op == stbs_pkg::OP_WRITE &&
					(32'(item.entry_index) < 32'(DEPTH));
				found_n       = 1'b0;
				pos_n         = '0;
			end
			stbs_pkg::ST_PROBE: begin
				mem_ctl.rd_en = !range_empty;
			end
			stbs_pkg::ST_CMP: begin
				rd_addr = AW'(mid_n);
				if (is_eq) begin
					found_n = 1'b1;
					pos_n   = mid_q;
				end else begin
					mem_ctl.rd_en = !last_probe;
				end
			end
			stbs_pkg::ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign wr_addr      = AW'(item.entry_index);
	assign wr_data      = item.entry_value;
	assign res.found    = found_q;
	assign res.position = pos_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Search registers: load on accept, narrow on each compare
	always_ff @(posedge clk) begin
		found_q <= found_n;
		pos_q   <= pos_n;
		if (state_q == stbs_pkg::ST_IDLE && accept) begin
			key_q <= item.search_key;
			lo_q  <= item.range_low;
			hi_q  <= hi_clamp;
		end else if (state_q == stbs_pkg::ST_PROBE) begin
			mid_q <= mid_c;
		end else if (state_q == stbs_pkg::ST_CMP) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
	end

endmodule

>>> design/stbs_checker.sv
// Port-level checks of the sorted-table search block, bound to the top level.
// Depends on stbs_pkg and the assertion macros header.
`include "sorted_table_binary_search_top_macros.svh"

module stbs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [stbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic [0:0]                       s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [stbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [0:0]                       m_axis_tuser
);

	logic wr_beat, srch_beat;

	assign wr_beat   = s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == stbs_pkg::OP_WRITE;
	assign srch_beat = s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == stbs_pkg::OP_SEARCH;

	// A stalled result holds
	`STBS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// A miss reports position zero
	`STBS_ASSERT_NOW(a_miss_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "miss with nonzero position")

	// A write never produces a result beat
	`STBS_ASSERT_NEXT(a_write_silent, clk, arst_n, wr_beat && !m_axis_tvalid, !m_axis_tvalid, "result after a write")

	// A search occupies the sequencer for at least the next cycle
	`STBS_ASSERT_NEXT(a_search_busy, clk, arst_n, srch_beat, !s_axis_tready, "input taken during a search")

	// Writes are taken back to back while the sequencer is free
	`STBS_ASSERT_NEXT(a_write_ready, clk, arst_n, wr_beat, s_axis_tready, "input stalled after a write")

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (.*);

>>> test/sorted_table_binary_search_top_tb.sv
// Self-checking testbench for the sorted-table binary search block.
// Depends on stbs_pkg and sorted_table_binary_search_top; loads the table,
// runs directed and random searches and checks each result beat in order.
`timescale 1ns / 100ps

module sorted_table_binary_search_top_tb;
	import stbs_pkg::*;

	localparam int DEPTH        = 64;
	localparam int ITEM_TARGET  = 1050;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]             s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]             m_axis_tuser;

	// Mirror of the table contents and the results still owed by the block
	logic signed [VAL_W-1:0] table_mirror [0:DEPTH-1];
	result_t                 pending_results [$];
	stim_row_t               directed_rows [$];
	int                      mismatch_count = 0;
	int                      items_sent = 0;
	bit                      sender_eager = 1'b0;
	int                      idle_cycles = 0;

	sorted_table_binary_search_top #(
		.DEPTH(DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s: got %0h, want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Walk the probe sequence over the mirrored table
	function automatic result_t binsearch_predict(logic signed [VAL_W-1:0] key,
			logic [IDX_W-1:0] lo_in, logic [IDX_W-1:0] hi_in);
		int      lo;
		int      hi;
		int      mid;
		result_t r;
		lo = lo_in;
		hi = hi_in;
		r  = '0;
		if (hi > DEPTH - 1)
			hi = DEPTH - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (key == table_mirror[mid]) begin
				r.found    = 1'b1;
				r.position = mid[IDX_W-1:0];
				break;
			end else if (key > table_mirror[mid]) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return r;
	endfunction

	// Unused fields of each item carry random bits
	function automatic item_t make_write(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
		item_t it;
		it.op          = OP_WRITE;
		it.entry_index = idx;
		it.entry_value = val;
		it.search_key  = $urandom;
		it.range_low   = IDX_W'($urandom);
		it.range_high  = IDX_W'($urandom);
		return it;
	endfunction

	function automatic item_t make_search(logic [VAL_W-1:0] key, logic [IDX_W-1:0] lo,
			logic [IDX_W-1:0] hi);
		item_t it;
		it.op          = OP_SEARCH;
		it.entry_index = IDX_W'($urandom);
		it.entry_value = $urandom;
		it.search_key  = key;
		it.range_low   = lo;
		it.range_high  = hi;
		return it;
	endfunction

	// Present one beat after a random gap; update the mirror once it is taken
	task automatic send_item(input item_t it, input bit typed, input result_t want);
		int gap;
		gap = sender_eager ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.op;
		s_axis_tdata  <= {6'b0, it.range_high, it.range_low, it.search_key,
			it.entry_value, it.entry_index};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		items_sent++;
		if (it.op == OP_WRITE) begin
			if (it.entry_index < DEPTH)
				table_mirror[it.entry_index] = it.entry_value;
		end else begin
			pending_results.push_back(typed ? want :
				binsearch_predict(it.search_key, it.range_low, it.range_high));
		end
	endtask

	// Load the whole table in ascending order; narrow spreads give duplicates
	task automatic load_ascending(input bit narrow);
		logic signed [VAL_W-1:0] vals [0:DEPTH-1];
		logic signed [VAL_W-1:0] tmp;
		int                      base;
		int                      j;
		base = $urandom;
		for (int i = 0; i < DEPTH; i++)
			vals[i] = narrow ? base + $urandom_range(0, 40) : $urandom;
		for (int i = 1; i < DEPTH; i++) begin
			tmp = vals[i];
			j   = i - 1;
			while (j >= 0 && vals[j] > tmp) begin
				vals[j+1] = vals[j];
				j--;
			end
			vals[j+1] = tmp;
		end
		if (!narrow && $urandom_range(0, 1)) begin
			vals[0]       = 32'h8000_0000;
			vals[DEPTH-1] = 32'h7fff_ffff;
		end
		for (int i = 0; i < DEPTH; i++)
			send_item(make_write(IDX_W'(i), vals[i]), 1'b0, '0);
	endtask

	// Random search, half of the time for a key held in the range
	task automatic send_random_search();
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic [VAL_W-1:0] key;
		int               pick;
		if ($urandom_range(0, 9) < 6) begin
			lo = '0;
			hi = IDX_W'(DEPTH - 1);
		end else begin
			lo = IDX_W'($urandom);
			hi = IDX_W'($urandom);
		end
		pick = $urandom_range(0, 9);
		if (pick < 5)
			key = table_mirror[lo <= hi ? $urandom_range(lo, hi) : $urandom_range(hi, lo)];
		else if (pick < 7)
			key = table_mirror[$urandom_range(0, DEPTH - 1)] + 1;
		else if (pick < 9)
			key = $urandom;
		else
			key = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
		send_item(make_search(key, lo, hi), 1'b0, '0);
	endtask

	// Receiver: random stalls, check each result beat against the oldest prediction
	initial begin
		int      stall;
		int      left_in_mode;
		bit      eager;
		result_t want;
		left_in_mode = 0;
		eager        = 1'b0;
		@(posedge arst_n);
		forever begin
			if (left_in_mode == 0) begin
				left_in_mode = $urandom_range(4, 20);
				eager        = ($urandom_range(0, 3) == 0);
			end
			left_in_mode--;
			stall = eager ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with no search pending",
					32'(m_axis_tdata), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser[0] !== want.found)
					report_mismatch("found flag", 32'(m_axis_tuser[0]), 32'(want.found));
				if (m_axis_tdata[IDX_W-1:0] !== want.position)
					report_mismatch("position", 32'(m_axis_tdata[IDX_W-1:0]),
						32'(want.position));
			end
		end
	end

	// Watchdog: end the run when neither side moves a beat for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		stim_row_t row;
		int        phase_kind;
		int        burst;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Known table: extremes at both ends, steps of 1000 around zero at index 31
		for (int i = 0; i < DEPTH; i++)
			send_item(make_write(IDX_W'(i), i == 0 ? 32'h8000_0000 :
				i == DEPTH - 1 ? 32'h7fff_ffff : (i - 31) * 1000), 1'b0, '0);

		// Directed rows: typed results where they are plain, else predicted
		directed_rows.push_back('{make_search(32'h8000_0000, 0, 63), 1'b1, {1'b1, 6'd0}});
		directed_rows.push_back('{make_search(32'h7fff_ffff, 0, 63), 1'b1, {1'b1, 6'd63}});
		directed_rows.push_back('{make_search(0, 0, 63), 1'b1, {1'b1, 6'd31}});
		directed_rows.push_back('{make_search(500, 0, 63), 1'b1, {1'b0, 6'd0}});
		directed_rows.push_back('{make_search(32'h8000_0001, 0, 63), 1'b1, {1'b0, 6'd0}});
		directed_rows.push_back('{make_search(9000, 40, 39), 1'b1, {1'b0, 6'd0}});
		directed_rows.push_back('{make_search(32'h7fff_ffff, 63, 63), 1'b1, {1'b1, 6'd63}});
		directed_rows.push_back('{make_search(32'h7fff_ffff, 63, 0), 1'b1, {1'b0, 6'd0}});
		directed_rows.push_back('{make_search(32'h8000_0000, 0, 0), 1'b1, {1'b1, 6'd0}});
		directed_rows.push_back('{make_search(-1000, 0, 63), 1'b0, '0});
		directed_rows.push_back('{make_search(5000, 40, 63), 1'b0, '0});
		directed_rows.push_back('{make_search(-30000, 1, 62), 1'b0, '0});
		// Duplicate entries next to the first probe
		directed_rows.push_back('{make_write(32, 0), 1'b0, '0});
		directed_rows.push_back('{make_write(30, 0), 1'b0, '0});
		directed_rows.push_back('{make_search(0, 0, 63), 1'b0, '0});
		directed_rows.push_back('{make_search(0, 32, 63), 1'b0, '0});
		// Break the order and search across the damage
		directed_rows.push_back('{make_write(20, 32'h7fff_ffff), 1'b0, '0});
		directed_rows.push_back('{make_write(45, 32'haaaa_aaaa), 1'b0, '0});
		directed_rows.push_back('{make_search(32'h7fff_ffff, 0, 63), 1'b0, '0});
		directed_rows.push_back('{make_search(32'haaaa_aaaa, 0, 63), 1'b0, '0});
		directed_rows.push_back('{make_search(-8000, 0, 63), 1'b0, '0});
		directed_rows.push_back('{make_search(32'h5555_5555, 21, 44), 1'b0, '0});
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_item(row.it, row.typed, row.want);
		end

		// Random phases: table reloads, search bursts and stray writes
		while (items_sent < ITEM_TARGET) begin
			sender_eager = ($urandom_range(0, 3) == 0);
			phase_kind   = $urandom_range(0, 99);
			if (phase_kind < 12) begin
				load_ascending($urandom_range(0, 2) == 0);
			end else begin
				burst = $urandom_range(8, 30);
				repeat (burst) begin
					if ($urandom_range(0, 19) == 0)
						send_item(make_write(IDX_W'($urandom), $urandom), 1'b0, '0);
					else
						send_random_search();
				end
			end
		end
		sender_eager = 1'b0;
		s_axis_tvalid <= 1'b0;

		// Drain, then let a stray beat show itself
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
